// ===== rtl/core/b64d_pkg.sv =====
// b64d_pkg: shared types, constants and the character map of the base64 stream decoder
// used by b64d_out_ser and base64_stream_decoder_core; no dependencies
package b64d_pkg;

	localparam int unsigned LIMIT_W = 13;

	localparam logic [LIMIT_W-1:0] OUT_LIMIT_RESET = 13'd256;
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// decoded bytes of one group, packed from slot 0, with how many are valid
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0] count;
		logic eot;
	} b64d_bundle_t;

	function automatic logic [5:0] sextet_of(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = 8'd0;
			if (c >= 8'h41 && c <= 8'h5A) begin
				d = c - 8'h41;
			end else if (c >= 8'h61 && c <= 8'h7A) begin
				d = c - 8'd71;
			end else if (c >= 8'h30 && c <= 8'h39) begin
				d = c + 8'd4;
			end else if (c == 8'h2B) begin
				d = 8'd62;
			end else if (c == 8'h2F) begin
				d = 8'd63;
			end
			return d[5:0];
		end
	endfunction

endpackage

// ===== rtl/core/b64d_in_if.sv =====
// b64d_in_if: valid/ready channel carrying one text character per item
// no dependencies
interface b64d_in_if;
	logic valid;
	logic ready;
	logic [7:0] in_char;
	logic end_of_text;

	modport source (output valid, output in_char, output end_of_text, input ready);
	modport sink (input valid, input in_char, input end_of_text, output ready);
endinterface

// ===== rtl/core/b64d_out_if.sv =====
// b64d_out_if: valid/ready channel carrying one decoded byte per item
// no dependencies
interface b64d_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic run_last;
	logic text_end;

	modport source (output valid, output out_byte, output run_last, output text_end,
		input ready);
	modport sink (input valid, input out_byte, input run_last, input text_end,
		output ready);
endinterface

// ===== rtl/core/b64d_out_ser.sv =====
// b64d_out_ser: holds one group's decoded bytes and sends them one item per cycle
// while data.ready is high; depends on b64d_pkg and b64d_out_if
module b64d_out_ser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  b64d_pkg::b64d_bundle_t load_bundle,
	output logic                  free,
	b64d_out_if.source            data
);
	import b64d_pkg::*;

	b64d_bundle_t bund_q;
	logic         bund_v_q;
	logic [1:0]   idx_q;
	logic         at_last;
	logic         pop;

	assign at_last = (idx_q == bund_q.count - 2'd1);
	assign pop     = bund_v_q && data.ready;
	assign free    = !bund_v_q || (data.ready && at_last);

	assign data.valid    = bund_v_q;
	assign data.out_byte = bund_q.bytes[idx_q];
	assign data.run_last = at_last;
	assign data.text_end = at_last && bund_q.eot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bund_v_q <= 1'b0;
			idx_q    <= 2'd0;
		end else if (load) begin
			bund_v_q <= 1'b1;
			idx_q    <= 2'd0;
		end else if (pop) begin
			if (at_last) begin
				bund_v_q <= 1'b0;
				idx_q    <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bund_q <= load_bundle;
		end
	end

endmodule

// ===== rtl/core/base64_stream_decoder_core.sv =====
// base64_stream_decoder_core: streaming base64 decoder, one character in per item
// depends on b64d_pkg, b64d_in_if, b64d_out_if and b64d_out_ser
//
// usage
// - text: one character per item with end_of_text on the final one
// - data: decoded bytes; run_last marks the last byte of a character,
//   text_end the final byte of the text
// - cfg_we / cfg_wdata: out_limit, to be written by the user only while the
//   block is idle; the block itself does not enforce this
// - a character is registered on accept and decoded in the next cycle; a
//   group's first byte is offered on data once the group's bytes are loaded
//   into the byte holder, then one byte per cycle while data.ready is high
// - a character that closes a group waits until the byte holder is free,
//   unless output is halted; other characters are taken every cycle
// - when data stalls, the byte holder fills and text.ready drops until it
//   drains
// - reset clears group state, byte count and halt flag; out_limit returns
//   to 256
module base64_stream_decoder_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [b64d_pkg::LIMIT_W-1:0] cfg_wdata,
	b64d_in_if.sink                      text,
	b64d_out_if.source                   data
);
	import b64d_pkg::*;

	logic [LIMIT_W-1:0] limit_q;

	logic         valid_s1;
	logic [7:0]   char_s1;
	logic         eot_s1;

	logic [17:0]        store_q;
	logic [1:0]         group_q;
	logic               tpad_q;
	logic [LIMIT_W-1:0] emitted_q;
	logic               halted_q;

	logic         free;
	logic         fire;
	logic         need;
	logic         halt_now;
	logic [5:0]   v;
	logic [17:0]  store_new;
	logic         tpad_new;
	logic         close;
	logic [5:0]   s0, s1, s2, s3;
	logic [7:0]   b0, b1, b2;
	logic         has1, has2;
	logic [1:0]   n;
	logic         load;
	b64d_bundle_t bundle;

	assign fire       = valid_s1 && (free || !need);
	assign text.ready = !valid_s1 || fire;

	always_comb begin
		v         = sextet_of(char_s1);
		halt_now  = halted_q || (group_q == 2'd0 &&
			!(({1'b0, emitted_q} + 14'd3) < {1'b0, limit_q}));
		store_new = (group_q == 2'd0) ? 18'd0 : store_q;
		tpad_new  = (group_q == 2'd0) ? 1'b0 : tpad_q;
		unique case (group_q)
			2'd0: store_new[17:12] = v;
			2'd1: store_new[11:6]  = v;
			2'd2: begin
				store_new[5:0] = v;
				tpad_new       = (char_s1 == PAD_CHAR);
			end
			default: ;
		endcase
		close = (group_q == 2'd3) || eot_s1;
		s0    = store_new[17:12];
		s1    = store_new[11:6];
		s2    = store_new[5:0];
		s3    = (group_q == 2'd3) ? v : 6'd0;
		b0    = {s0, s1[5:4]};
		b1    = {s1[3:0], s2[5:2]};
		b2    = {s2[1:0], s3};
		has1  = (group_q >= 2'd2) && !tpad_new;
		has2  = (group_q == 2'd3) && (char_s1 != PAD_CHAR);
		n     = 2'd1 + {1'b0, has1} + {1'b0, has2};
		need  = !halt_now && close;
		load  = fire && need;

		bundle.bytes[0] = b0;
		bundle.bytes[1] = has1 ? b1 : b2;
		bundle.bytes[2] = b2;
		bundle.count    = n;
		bundle.eot      = eot_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= OUT_LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			char_s1 <= text.in_char;
			eot_s1  <= text.end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q   <= 18'd0;
			group_q   <= 2'd0;
			tpad_q    <= 1'b0;
			emitted_q <= '0;
			halted_q  <= 1'b0;
		end else if (fire) begin
			if (eot_s1) begin
				store_q   <= 18'd0;
				group_q   <= 2'd0;
				tpad_q    <= 1'b0;
				emitted_q <= '0;
				halted_q  <= 1'b0;
			end else if (halt_now) begin
				halted_q <= 1'b1;
			end else if (close) begin
				store_q   <= 18'd0;
				group_q   <= 2'd0;
				tpad_q    <= 1'b0;
				emitted_q <= emitted_q + {{(LIMIT_W-2){1'b0}}, n};
			end else begin
				store_q <= store_new;
				group_q <= group_q + 2'd1;
				tpad_q  <= tpad_new;
			end
		end
	end

	b64d_out_ser u_out_ser (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.load_bundle (bundle),
		.free        (free),
		.data        (data)
	);

endmodule

// ===== bench/tb_base64_stream_decoder_core.sv =====
`timescale 1ns / 1ps

// tb_base64_stream_decoder_core: self-checking bench for the streaming base64 decoder
// sends characters on b64d_in_if and checks decoded bytes on b64d_out_if with a predictor
// depends on b64d_pkg, b64d_in_if, b64d_out_if and base64_stream_decoder_core

module tb_base64_stream_decoder_core;
	import b64d_pkg::*;

	typedef struct packed {
		logic [7:0] value;
		logic run_last;
		logic text_end;
	} dec_byte_t;

	typedef struct packed {
		logic [7:0] ch;
		logic eot;
		logic typed;
		logic [1:0] n;
		logic [23:0] bytes;
	} dir_row_t;

	localparam int N_DIR = 24;
	localparam int N_PHASE = 6;

	dir_row_t dir_rows [N_DIR] = '{
		'{8'h54, 1'b0, 1'b1, 2'd0, 24'h000000},
		'{8'h57, 1'b0, 1'b1, 2'd0, 24'h000000},
		'{8'h46, 1'b0, 1'b1, 2'd0, 24'h000000},
		'{8'h75, 1'b0, 1'b1, 2'd3, 24'h4D616E},
		'{8'h41, 1'b0, 1'b0, 2'd0, 24'h000000},
		'{8'h42, 1'b0, 1'b0, 2'd0, 24'h000000},
		'{PAD_CHAR, 1'b0, 1'b0, 2'd0, 24'h000000},
		'{8'h43, 1'b0, 1'b0, 2'd0, 24'h000000},
		'{8'h2F, 1'b0, 1'b1, 2'd0, 24'h000000},
		'{8'h2F, 1'b0, 1'b1, 2'd0, 24'h000000},
		'{PAD_CHAR, 1'b0, 1'b1, 2'd0, 24'h000000},
		'{PAD_CHAR, 1'b0, 1'b1, 2'd1, 24'hFF0000},
		'{8'h2F, 1'b0, 1'b1, 2'd0, 24'h000000},
		'{8'h2F, 1'b0, 1'b1, 2'd0, 24'h000000},
		'{8'h2F, 1'b0, 1'b1, 2'd0, 24'h000000},
		'{8'h2F, 1'b0, 1'b1, 2'd3, 24'hFFFFFF},
		'{8'hFF, 1'b0, 1'b0, 2'd0, 24'h000000},
		'{8'h80, 1'b0, 1'b0, 2'd0, 24'h000000},
		'{8'h01, 1'b0, 1'b0, 2'd0, 24'h000000},
		'{8'h39, 1'b0, 1'b0, 2'd0, 24'h000000},
		'{8'h7A, 1'b1, 1'b1, 2'd1, 24'hCC0000},
		'{8'h51, 1'b0, 1'b0, 2'd0, 24'h000000},
		'{8'h55, 1'b0, 1'b0, 2'd0, 24'h000000},
		'{8'h49, 1'b1, 1'b0, 2'd0, 24'h000000}
	};

	int ph_limit [N_PHASE] = '{4096, 4, 8191, 13, 0, 256};
	int ph_snd [N_PHASE] = '{0, 88, 0, 28, 0, 88};
	int ph_rcv [N_PHASE] = '{0, 0, 88, 28, 0, 28};
	int ph_hold [N_PHASE] = '{300, 0, 0, 0, 0, 0};
	int ph_target [N_PHASE] = '{40, 12, 30, 30, 0, 30};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [LIMIT_W-1:0] cfg_wdata = '0;

	b64d_in_if text_if ();
	b64d_out_if data_if ();

	base64_stream_decoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.text(text_if),
		.data(data_if)
	);

	logic [17:0] grp_bits;
	logic [1:0] grp_fill;
	logic pad_third;
	logic [12:0] byte_cnt;
	logic stopped;
	logic [LIMIT_W-1:0] limit_val = OUT_LIMIT_RESET;
	logic [7:0] dec_out [3];
	int dec_n;
	logic dec_live;
	dec_byte_t pending_bytes [$];

	int n_fail = 0;
	int snd_pct = 0;
	int rcv_pct = 0;
	int hold_left = 0;
	int live_items = 0;

	always #5 clk = ~clk;

	function automatic logic [5:0] char_sextet(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A) return 6'(c - 8'h41);
		if (c >= 8'h61 && c <= 8'h7A) return 6'(c - 8'h61 + 8'd26);
		if (c >= 8'h30 && c <= 8'h39) return 6'(c - 8'h30 + 8'd52);
		if (c == 8'h2B) return 6'd62;
		if (c == 8'h2F) return 6'd63;
		return 6'd0;
	endfunction

	function automatic logic [7:0] index_char(input int i);
		if (i < 26) return 8'(8'h41 + i);
		if (i < 52) return 8'(8'h61 + i - 26);
		if (i < 62) return 8'(8'h30 + i - 52);
		if (i == 62) return 8'h2B;
		return 8'h2F;
	endfunction

	task automatic clear_text();
		grp_bits = '0;
		grp_fill = '0;
		pad_third = 1'b0;
		byte_cnt = '0;
		stopped = 1'b0;
	endtask

	task automatic decode_char(input logic [7:0] c, input logic eot);
		logic [5:0] v, s0, s1, s2, s3;
		int pos;
		pos = grp_fill;
		dec_n = 0;
		dec_live = 1'b0;
		if (pos == 0 && !stopped && !(int'(byte_cnt) + 3 < int'(limit_val))) begin
			stopped = 1'b1;
		end
		if (stopped) begin
			if (eot) begin
				clear_text();
			end
			return;
		end
		dec_live = 1'b1;
		v = char_sextet(c);
		if (pos == 0) begin
			grp_bits = '0;
			pad_third = 1'b0;
		end
		if (pos < 3) begin
			grp_bits[17-6*pos -: 6] = v;
		end
		if (pos == 2) begin
			pad_third = (c == PAD_CHAR);
		end
		if (pos == 3 || eot) begin
			s0 = grp_bits[17:12];
			s1 = grp_bits[11:6];
			s2 = grp_bits[5:0];
			s3 = (pos == 3) ? v : 6'd0;
			dec_out[0] = {s0, s1[5:4]};
			dec_n = 1;
			if (pos >= 2 && !pad_third) begin
				dec_out[dec_n] = {s1[3:0], s2[5:2]};
				dec_n = dec_n + 1;
			end
			if (pos == 3 && c != PAD_CHAR) begin
				dec_out[dec_n] = {s2[1:0], s3};
				dec_n = dec_n + 1;
			end
			byte_cnt = byte_cnt + 13'(dec_n);
			grp_fill = '0;
			grp_bits = '0;
			pad_third = 1'b0;
		end else begin
			grp_fill = grp_fill + 2'd1;
		end
		if (eot) begin
			clear_text();
		end
	endtask

	task automatic send_char(input dir_row_t row);
		int i;
		while (snd_pct > 0 && $urandom_range(0, 99) < snd_pct) begin
			text_if.valid <= 1'b0;
			@(posedge clk);
		end
		text_if.valid <= 1'b1;
		text_if.in_char <= row.ch;
		text_if.end_of_text <= row.eot;
		@(negedge clk);
		while (text_if.ready !== 1'b1) begin
			@(negedge clk);
		end
		decode_char(row.ch, row.eot);
		if (dec_live) begin
			live_items++;
		end
		if (row.typed) begin
			for (i = 0; i < row.n; i++) begin
				pending_bytes.push_back('{row.bytes[23-8*i -: 8], i == row.n - 1,
					i == row.n - 1 && row.eot});
			end
		end else begin
			for (i = 0; i < dec_n; i++) begin
				pending_bytes.push_back('{dec_out[i], i == dec_n - 1, i == dec_n - 1 && row.eot});
			end
		end
		@(posedge clk);
	endtask

	task automatic send_text();
		logic [7:0] chars [$];
		int kind, len, i;
		dir_row_t row;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			len = $urandom_range(1, 12);
			for (i = 0; i < len; i++) begin
				chars.push_back(8'($urandom_range(1, 255)));
			end
		end else begin
			len = 4 * $urandom_range(1, 5);
			if ($urandom_range(0, 3) == 0) begin
				len = len - $urandom_range(1, 3);
			end
			for (i = 0; i < len; i++) begin
				chars.push_back(index_char($urandom_range(0, 63)));
			end
			if (len % 4 == 0 && $urandom_range(0, 2) == 0) begin
				chars[len-1] = PAD_CHAR;
				if ($urandom_range(0, 1) == 1) begin
					chars[len-2] = PAD_CHAR;
				end
			end
			// stray pad somewhere in the text
			if (kind == 1) begin
				chars[$urandom_range(0, len - 1)] = PAD_CHAR;
			end
		end
		row = '0;
		for (i = 0; i < len; i++) begin
			row.ch = chars[i];
			row.eot = (i == len - 1);
			send_char(row);
		end
	endtask

	task automatic wait_idle();
		while (pending_bytes.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_limit(input int value);
		cfg_we <= 1'b1;
		cfg_wdata <= LIMIT_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_val = LIMIT_W'(value);
	endtask

	initial begin
		data_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				data_if.ready <= 1'b0;
				hold_left--;
			end else if (rcv_pct > 0 && $urandom_range(0, 99) < rcv_pct) begin
				data_if.ready <= 1'b0;
			end else begin
				data_if.ready <= 1'b1;
			end
		end
	end

	always @(negedge clk) begin : byte_check
		dec_byte_t want;
		if (arst_n && data_if.valid === 1'b1 && data_if.ready === 1'b1) begin
			if (pending_bytes.size() == 0) begin
				n_fail++;
				if (n_fail <= 10) begin
					$display("unexpected byte %02h run_last %b text_end %b", data_if.out_byte,
						data_if.run_last, data_if.text_end);
				end
			end else begin
				want = pending_bytes.pop_front();
				if (data_if.out_byte !== want.value || data_if.run_last !== want.run_last ||
					data_if.text_end !== want.text_end) begin
					n_fail++;
					if (n_fail <= 10) begin
						$display("byte mismatch: expected %02h %b %b, got %02h %b %b",
							want.value, want.run_last, want.text_end, data_if.out_byte,
							data_if.run_last, data_if.text_end);
					end
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int p, texts;
		text_if.valid = 1'b0;
		text_if.in_char = 8'h41;
		text_if.end_of_text = 1'b0;
		clear_text();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (p = 0; p < N_DIR; p++) begin
			send_char(dir_rows[p]);
		end
		for (p = 0; p < N_PHASE; p++) begin
			text_if.valid <= 1'b0;
			wait_idle();
			write_limit(ph_limit[p]);
			snd_pct = ph_snd[p];
			rcv_pct = ph_rcv[p];
			hold_left = ph_hold[p];
			live_items = 0;
			texts = 0;
			while (live_items < ph_target[p] || texts < 3) begin
				send_text();
				texts++;
			end
		end
		text_if.valid <= 1'b0;
		wait_idle();
		if (n_fail == 0 && pending_bytes.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== base64_stream_decoder_core.f =====
rtl/core/b64d_pkg.sv
rtl/core/b64d_in_if.sv
rtl/core/b64d_out_if.sv
rtl/core/b64d_out_ser.sv
rtl/core/base64_stream_decoder_core.sv
bench/tb_base64_stream_decoder_core.sv
